### rtl/lpd_pkg.sv
// lpd_pkg: shared types and constants for the length-prefix deframer
// holds the result-kind codes, the flag byte limits and the result record
// no dependencies
`default_nettype none

package lpd_pkg;

   // flag byte codes
   localparam logic [7:0] FLAG_MAX_SHORT = 8'd125;
   localparam logic [7:0] FLAG_LEN16     = 8'd126;
   localparam logic [7:0] FLAG_LEN32     = 8'd127;

   // extended length byte counts
   localparam logic [2:0] LEN16_BYTES = 3'd2;
   localparam logic [2:0] LEN32_BYTES = 3'd4;

   // result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_BADFLAG = 2'd2
   } kind_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      kind_type   kind;
   } result_type;

endpackage

`default_nettype wire

### rtl/lpd_parser.sv
// lpd_parser: frame header parser and payload counter
// takes one byte per go pulse, updates the frame state, flags at most one result
// depends on lpd_pkg
`default_nettype none

module lpd_parser
   import lpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       go,
   input  wire logic [7:0] in_byte,
   output logic            push,
   output result_type      result
);

   typedef enum logic [1:0] {
      PH_FLAG    = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  len_left_ff, len_left_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] pay_left_ff, pay_left_in;

   // frame start candidate and helpers
   logic [31:0] start_len;
   logic        start_frame;
   logic [31:0] acc_shift;
   logic [2:0]  len_left_dec;
   logic [31:0] pay_left_dec;

   assign acc_shift    = {accum_ff[23:0], in_byte};
   assign len_left_dec = (len_left_ff != 3'd0) ? len_left_ff - 3'd1 : 3'd0;
   assign pay_left_dec = (pay_left_ff != 32'd0) ? pay_left_ff - 32'd1 : 32'd0;

   // next state and result for one byte
   always_comb begin
      phase_in    = phase_ff;
      len_left_in = len_left_ff;
      accum_in    = accum_ff;
      pay_left_in = pay_left_ff;
      push        = 1'b0;
      result      = '{out_byte: 8'd0, last: 1'b0, kind: KIND_PAYLOAD};
      start_frame = 1'b0;
      start_len   = 32'd0;

      unique case (phase_ff)
         PH_PAYLOAD: begin
            push            = 1'b1;
            result.out_byte = in_byte;
            result.last     = (pay_left_ff <= 32'd1);
            pay_left_in     = pay_left_dec;
            if (pay_left_dec == 32'd0) begin
               phase_in = PH_FLAG;
            end
         end
         PH_LENGTH: begin
            accum_in    = acc_shift;
            len_left_in = len_left_dec;
            if (len_left_dec == 3'd0) begin
               start_frame = 1'b1;
               start_len   = acc_shift;
            end
         end
         default: begin
            // waiting for a flag byte, unused code behaves the same
            phase_in = PH_FLAG;
            if (in_byte <= FLAG_MAX_SHORT) begin
               start_frame = 1'b1;
               start_len   = {24'd0, in_byte};
            end else if (in_byte == FLAG_LEN16 || in_byte == FLAG_LEN32) begin
               len_left_in = (in_byte == FLAG_LEN16) ? LEN16_BYTES : LEN32_BYTES;
               accum_in    = 32'd0;
               phase_in    = PH_LENGTH;
            end else begin
               push        = 1'b1;
               result.kind = KIND_BADFLAG;
            end
         end
      endcase

      // begin a frame: empty frames report at once
      if (start_frame) begin
         if (start_len == 32'd0) begin
            phase_in    = PH_FLAG;
            pay_left_in = 32'd0;
            push        = 1'b1;
            result.last = 1'b1;
            result.kind = KIND_EMPTY;
         end else begin
            pay_left_in = start_len;
            phase_in    = PH_PAYLOAD;
         end
      end

      if (!go) begin
         push = 1'b0;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FLAG;
         len_left_ff <= 3'd0;
         accum_ff    <= 32'd0;
         pay_left_ff <= 32'd0;
      end else if (go) begin
         phase_ff    <= phase_in;
         len_left_ff <= len_left_in;
         accum_ff    <= accum_in;
         pay_left_ff <= pay_left_in;
      end
   end

   // payload phase always has bytes due
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> pay_left_ff != 32'd0)
      else $error("payload phase with no bytes due");

   // length phase always has length bytes due
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LENGTH |-> len_left_ff != 3'd0)
      else $error("length phase with no length bytes due");

   // a last payload byte returns the parser to the flag phase
   assert property (@(posedge clock) disable iff (reset)
      push && result.kind == KIND_PAYLOAD && result.last |=> phase_ff == PH_FLAG)
      else $error("parser did not return to flag phase after last byte");

endmodule

`default_nettype wire

### rtl/lpd_out_fifo.sv
// lpd_out_fifo: two-entry result queue in front of the result channel
// keeps the parser running while the receiver stalls, until the queue is full
// depends on lpd_pkg
`default_nettype none

module lpd_out_fifo
   import lpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  result_type      push_data,
   output logic            full,
   output logic            out_valid,
   input  wire logic       out_stall,
   output result_type      out_data
);

   result_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && !out_stall;
   assign out_data  = mem_ff[rd_ptr_ff];

   // occupancy after this cycle's transfers
   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   // never written while full
   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result queue overflow");

   // count agrees with pointer distance
   assert property (@(posedge clock) disable iff (reset)
      count_ff[0] == (wr_ptr_ff ^ rd_ptr_ff))
      else $error("result queue count and pointers disagree");

   // a stalled result stays valid and unchanged
   assert property (@(posedge clock) disable iff (reset)
      out_valid && out_stall |=> out_valid && out_data == $past(out_data))
      else $error("stalled result changed");

endmodule

`default_nettype wire

### rtl/length_prefix_deframer_top.sv
// length_prefix_deframer_top: byte-stream deframer for length-prefixed frames
// instantiates lpd_parser and lpd_out_fifo, depends on lpd_pkg
//
// Usage
//   The req_ channel carries one stream byte per transfer. A flag byte of
//   0..125 is the frame length, 126 is followed by a 16-bit big-endian length,
//   127 by a 32-bit big-endian length. Payload bytes come out on the rsp_
//   channel one per transfer, kind payload, with rsp_last on the final byte.
//   A zero-length frame gives one empty-frame transfer with rsp_last set, and
//   a flag byte of 128..255 gives one bad-flag transfer and is dropped.
//   Header bytes of a nonzero frame give no transfer.
//   Path: a byte is registered at the input, parsed from that register once
//   the queue has room, and written to a two-entry result queue, from which
//   its result is presented on the rsp_ channel.
//   Throughput: one byte per cycle while req_stall is low.
//   Stall: when the receiver stalls, results collect in the queue; once it
//   is full and a byte is waiting in the input register, req_stall rises.
//   req_stall comes from registers only.
//   Reset clears the input valid bit, the queue and the parser, which then
//   waits for a flag byte.
`default_nettype none

module length_prefix_deframer_top
   import lpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last,
   output logic [1:0]      rsp_kind
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       go;
   logic       push;
   logic       full;
   result_type result;
   result_type out_data;

   // the parser runs when a byte is held and the queue has room
   assign go        = in_valid_ff && !full;
   assign req_stall = in_valid_ff && full;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   lpd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .in_byte (in_byte_ff),
      .push    (push),
      .result  (result)
   );

   lpd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   // result fields
   assign rsp_out_byte = out_data.out_byte;
   assign rsp_last     = out_data.last;
   assign rsp_kind     = out_data.kind;

   // stall only with a byte waiting
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with no byte waiting");

   // a stalled byte stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && in_byte_ff == $past(in_byte_ff))
      else $error("held byte lost during stall");

   // no transfer on a result before the queue can have one
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
